[rtl/tcw_pkg.sv]
// Shared constants, types and helpers for the text console cursor writer.
package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int IDX_W    = 11;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int DATA_W   = CHAR_W + COLOR_W;
    localparam int ACTION_W = 3;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_BLANK     = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd11;

    localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 3'd0,
        ACT_LEFT  = 3'd1,
        ACT_RIGHT = 3'd2,
        ACT_UP    = 3'd3,
        ACT_DOWN  = 3'd4
    } action_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [DATA_W-1:0]  data;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } step_t;

    function automatic logic [IDX_W-1:0] cell_index(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        logic [31:0] full;
        full = 32'(r) * 32'(COLUMNS) + 32'(c);
        return full[IDX_W-1:0];
    endfunction

endpackage

[rtl/tcw_step.sv]
// Next cursor and cell write for one command, given the current cursor.
module tcw_step (
    input  logic [tcw_pkg::ACTION_W-1:0] action,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::ROW_W-1:0]    row,
    input  logic [tcw_pkg::COL_W-1:0]    col,
    input  logic [tcw_pkg::COLOR_W-1:0]  color,
    output tcw_pkg::step_t               step
);
    import tcw_pkg::*;

    function automatic logic [ROW_W-1:0] next_row_wrapped(input logic [ROW_W-1:0] r);
        logic [ROW_W:0] inc;
        inc = {1'b0, r} + (ROW_W+1)'(1);
        return (inc >= (ROW_W+1)'(ROWS)) ? ROW_FIRST : inc[ROW_W-1:0];
    endfunction

    logic [ROW_W-1:0] put_row;
    logic [COL_W-1:0] put_col;
    logic [COL_W:0]   col_inc;

    // Banner line is reserved: a put on row 0 starts from row 1, column 0
    assign put_row = (row == '0) ? ROW_FIRST : row;
    assign put_col = (row == '0) ? '0 : col;
    assign col_inc = {1'b0, put_col} + (COL_W+1)'(1);

    always_comb
    begin
        step.we   = 1'b0;
        step.addr = '0;
        step.data = '0;
        step.row  = row;
        step.col  = col;
        case (action_t'(action))
            ACT_PUT:
            begin
                step.row = put_row;
                step.col = put_col;
                if (char_code == CH_NEWLINE)
                begin
                    step.col = '0;
                    step.row = next_row_wrapped(put_row);
                end
                else if (char_code == CH_BACKSPACE)
                begin
                    if (put_col != '0)
                    begin
                        step.col = put_col - COL_W'(1);
                        step.we  = 1'b1;
                    end
                    else if (put_row > ROW_FIRST)
                    begin
                        step.row = put_row - ROW_W'(1);
                        step.col = COL_LAST;
                        step.we  = 1'b1;
                    end
                    if (step.we)
                    begin
                        step.addr = cell_index(step.row, step.col);
                        step.data = {color, CH_BLANK};
                    end
                end
                else
                begin
                    step.we   = 1'b1;
                    step.addr = cell_index(put_row, put_col);
                    step.data = {color, char_code};
                    // Wrap to the next line at the end of a row
                    if (col_inc >= (COL_W+1)'(COLUMNS))
                    begin
                        step.col = '0;
                        step.row = next_row_wrapped(put_row);
                    end
                    else
                    begin
                        step.col = col_inc[COL_W-1:0];
                    end
                end
            end
            ACT_LEFT:
            begin
                if (col != '0)
                begin
                    step.col = col - COL_W'(1);
                end
                else if (row > ROW_FIRST)
                begin
                    step.row = row - ROW_W'(1);
                    step.col = COL_LAST;
                end
            end
            ACT_RIGHT:
            begin
                if (col < COL_LAST)
                begin
                    step.col = col + COL_W'(1);
                end
                else if (row < ROW_LAST)
                begin
                    step.row = row + ROW_W'(1);
                    step.col = '0;
                end
            end
            ACT_UP:
            begin
                if (row > ROW_FIRST)
                begin
                    step.row = row - ROW_W'(1);
                end
            end
            ACT_DOWN:
            begin
                if (row < ROW_LAST)
                begin
                    step.row = row + ROW_W'(1);
                end
            end
            default:
            begin
                step.we = 1'b0;
            end
        endcase
    end

endmodule

[rtl/text_console_cursor_writer.sv]
// Text console cursor writer: input register, command step, result register.
// An accepted item loads the input register; its result loads the result register when stage 1 fires.
// Throughput: one item per cycle while out_stall is low; the cursor register is updated by the step
// logic in the same cycle as the result register loads.
// Reset clears the cursor to row 0, column 0, empties both stages and sets
// the attribute byte to 11.
module text_console_cursor_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          text_color_we,
    input  logic [tcw_pkg::COLOR_W-1:0]   text_color_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcw_pkg::ACTION_W-1:0]  action,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          write_enable,
    output logic [tcw_pkg::IDX_W-1:0]     write_address,
    output logic [tcw_pkg::DATA_W-1:0]    write_data,
    output logic [tcw_pkg::IDX_W-1:0]     cursor_position
);
    import tcw_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    logic [ACTION_W-1:0] s1_action_reg;
    logic [CHAR_W-1:0]   s1_char_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic                out_valid_reg, out_valid_next;
    logic                out_we_reg;
    logic [IDX_W-1:0]    out_addr_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [IDX_W-1:0]    out_pos_reg;

    logic   accept;
    logic   s1_adv;
    logic   fire;
    step_t  step;

    // Stage 1 moves on whenever the result register is free or being emptied
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    tcw_step u_step (
        .action    (s1_action_reg),
        .char_code (s1_char_reg),
        .row       (row_reg),
        .col       (col_reg),
        .color     (color_reg),
        .step      (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= COLOR_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                row_reg <= step.row;
                col_reg <= step.col;
            end
            if (text_color_we)
            begin
                color_reg <= text_color_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action;
            s1_char_reg   <= char_code;
        end
        if (fire)
        begin
            out_we_reg   <= step.we;
            out_addr_reg <= step.addr;
            out_data_reg <= step.data;
            out_pos_reg  <= cell_index(step.row, step.col);
        end
    end

    assign out_valid       = out_valid_reg;
    assign write_enable    = out_we_reg;
    assign write_address   = out_addr_reg;
    assign write_data      = out_data_reg;
    assign cursor_position = out_pos_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg < ROW_W'(ROWS - 1) || row_reg == ROW_LAST) && col_reg <= COL_LAST)
        else $error("cursor left the screen");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_we_reg |-> out_addr_reg == '0 && out_data_reg == '0)
        else $error("result without write carries address or data");

    a_pos_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_pos_reg == cell_index(row_reg, col_reg))
        else $error("reported position differs from cursor register");

endmodule
